FILE: sv/avgov_pkg.sv
package avgov_pkg;

    localparam int RATE_W               = 16;
    localparam int FRAC_W               = 8;
    localparam int FRAMES_W             = 5;
    localparam int DEFAULT_SAMPLE_COUNT = 16;

    localparam logic [RATE_W-1:0]   DEFAULT_TARGET       = 16'd7680;
    localparam logic [FRAC_W-1:0]   DEFAULT_OFF_FRACTION = 8'd230;
    localparam logic [RATE_W-1:0]   ONE_FPS              = 16'd128;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX           = 5'd31;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_ADAPTIVE_ENABLE = 2'd0;
    localparam logic [1:0] REG_TARGET_RATE     = 2'd1;
    localparam logic [1:0] REG_OFF_FRACTION    = 2'd2;
    localparam logic [1:0] REG_SAMPLING_ENABLE = 2'd3;

    // Input item kinds
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_REFILL = 1'b1;

    typedef struct packed {
        logic shift;   // take the neighbor's sample
        logic load;    // take the fill value
    } t_cell_ctrl;

endpackage

FILE: sv/avgov_cell.sv
module avgov_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  avgov_pkg::t_cell_ctrl       i_ctrl,
    input  logic [avgov_pkg::RATE_W-1:0] i_prev,
    input  logic [avgov_pkg::RATE_W-1:0] i_fill,
    output logic [avgov_pkg::RATE_W-1:0] o_value
);
    import avgov_pkg::*;

    logic [RATE_W-1:0] r_value;
    logic [RATE_W-1:0] n_value;

    // Load wins over shift; a refill never shifts in the same cycle.
    always_comb begin
        priority if (i_ctrl.load) begin
            n_value = i_fill;
        end else if (i_ctrl.shift) begin
            n_value = i_prev;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= DEFAULT_TARGET;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

FILE: sv/avgov_mean.sv
module avgov_mean #(
    parameter  int SAMPLE_COUNT = avgov_pkg::DEFAULT_SAMPLE_COUNT,
    localparam int SUM_W        = avgov_pkg::RATE_W + $clog2(SAMPLE_COUNT)
) (
    input  logic [SUM_W-1:0]             i_sum,
    output logic [avgov_pkg::RATE_W-1:0] o_mean
);
    import avgov_pkg::*;

    // floor(sum / N) as sum * ceil(2^(SUM_W+L) / N) >> (SUM_W+L), exact for any SUM_W-bit sum
    localparam int          L       = $clog2(SAMPLE_COUNT);
    localparam int          SHIFT   = SUM_W + L;
    localparam int          MULT_W  = SUM_W + 1;
    localparam logic [63:0] MULT_64 = ((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1)
                                      / 64'(SAMPLE_COUNT);
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_64);

    logic [SUM_W+MULT_W-1:0] product;

    assign product = (SUM_W+MULT_W)'(i_sum) * (SUM_W+MULT_W)'(MULT);
    assign o_mean  = product[SHIFT +: RATE_W];

endmodule

FILE: sv/adaptive_vsync_governor.sv
// Adaptive vsync governor.
// Input stream: one request per frame. tuser carries the kind (frame
// measurement or ring refill), tdata the measured frame rate in Q9.7 fps.
// Output stream: one request per input request, in order. tdata carries the
// vsync decision, a toggle pulse and the ring average (Q9.7 fps).
// A frame request is clamped to the target rate and, after 31 frames and
// with sampling on, shifted into a chain of SAMPLE_COUNT sample cells; the
// oldest sample drops out of the far end and a running sum tracks the ring.
// Hysteresis: vsync drops at or below off_fraction * target and returns at
// or above target minus one fps. Thresholds are precomputed at register
// write time, so the sum update and both compares fit in the accept cycle.
// An accepted request is registered in the state stage; the reciprocal multiply
// that forms the average then feeds the output register. Throughput: one request
// per cycle unless output stalls; the cell chain shifts at most once per accepted request.
// The output register and the middle stage hold up to two requests, so input
// is still taken while a result waits; a stall on the output fills both
// stages and only then drops o_s_tready.
// Reset: synchronous; all cells return to the default target and the sum to N
// times it; vsync on, warm-up counter cleared, registers to their defaults.
// Configuration: APB, registers at byte addresses 0, 4, 8, 12.
module adaptive_vsync_governor #(
    parameter  int SAMPLE_COUNT = avgov_pkg::DEFAULT_SAMPLE_COUNT,
    localparam int SUM_W        = avgov_pkg::RATE_W + $clog2(SAMPLE_COUNT)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] measured_rate
    input  logic        i_s_tuser,   // [0] kind
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] vsync_on, [1] vsync_changed, [17:2] average_rate
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import avgov_pkg::*;

    localparam int LIM_W = SUM_W + FRAC_W;

    localparam logic [SUM_W-1:0] RESET_SUM =
        SUM_W'(64'(DEFAULT_TARGET) * 64'(SAMPLE_COUNT));
    localparam logic [LIM_W-1:0] RESET_OFF_LIMIT =
        LIM_W'(64'(DEFAULT_OFF_FRACTION) * 64'(DEFAULT_TARGET) * 64'(SAMPLE_COUNT));
    localparam logic [SUM_W-1:0] RESET_ON_LIMIT =
        SUM_W'(64'(DEFAULT_TARGET - ONE_FPS) * 64'(SAMPLE_COUNT));

    // ---------------- configuration registers ----------------
    logic              r_adaptive;
    logic [RATE_W-1:0] r_target;
    logic [FRAC_W-1:0] r_frac;
    logic              r_sampling;
    logic [LIM_W-1:0]  r_off_limit;   // off_fraction * target * N
    logic [SUM_W-1:0]  r_on_limit;    // (target - 1 fps) * N
    logic              r_on_always;   // target below one fps

    logic              cfg_wr;
    logic [1:0]        cfg_idx;
    logic [RATE_W-1:0] lim_target;
    logic [FRAC_W-1:0] lim_frac;
    logic [23:0]       lim_prod;
    logic [LIM_W-1:0]  n_off_limit;
    logic [SUM_W-1:0]  n_on_limit;
    logic              n_on_always;

    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = i_paddr[3:2];
    assign o_pready = 1'b1;

    // Rebuild the thresholds from the value being written and the other
    // register, so they are valid on the very next cycle.
    always_comb begin
        lim_target = r_target;
        lim_frac   = r_frac;
        if (cfg_idx == REG_TARGET_RATE) begin
            lim_target = i_pwdata[RATE_W-1:0];
        end
        if (cfg_idx == REG_OFF_FRACTION) begin
            lim_frac = i_pwdata[FRAC_W-1:0];
        end
        lim_prod    = 24'(lim_frac) * 24'(lim_target);
        n_off_limit = LIM_W'(LIM_W'(lim_prod) * LIM_W'(SAMPLE_COUNT));
        n_on_always = lim_target < ONE_FPS;
        n_on_limit  = SUM_W'(SUM_W'(lim_target - ONE_FPS) * SUM_W'(SAMPLE_COUNT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adaptive  <= 1'b1;
            r_target    <= DEFAULT_TARGET;
            r_frac      <= DEFAULT_OFF_FRACTION;
            r_sampling  <= 1'b1;
            r_off_limit <= RESET_OFF_LIMIT;
            r_on_limit  <= RESET_ON_LIMIT;
            r_on_always <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ADAPTIVE_ENABLE: r_adaptive <= i_pwdata[0];
                REG_TARGET_RATE:     r_target   <= i_pwdata[RATE_W-1:0];
                REG_OFF_FRACTION:    r_frac     <= i_pwdata[FRAC_W-1:0];
                REG_SAMPLING_ENABLE: r_sampling <= i_pwdata[0];
                default: ;
            endcase
            r_off_limit <= n_off_limit;
            r_on_limit  <= n_on_limit;
            r_on_always <= n_on_always;
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ADAPTIVE_ENABLE: o_prdata = {31'd0, r_adaptive};
            REG_TARGET_RATE:     o_prdata = {16'd0, r_target};
            REG_OFF_FRACTION:    o_prdata = {24'd0, r_frac};
            REG_SAMPLING_ENABLE: o_prdata = {31'd0, r_sampling};
            default:             o_prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline handshake ----------------
    logic r_v1;
    logic r_v2;
    logic s_accept;
    logic s1_move;

    assign s1_move    = r_v1 && (!r_v2 || i_m_tready);
    assign o_s_tready = !r_v1 || s1_move;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_v2;

    // ---------------- governor state ----------------
    logic [SUM_W-1:0]    r_sum;
    logic [FRAMES_W-1:0] r_frames;
    logic                r_vsync;
    logic [SUM_W-1:0]    n_sum;
    logic [FRAMES_W-1:0] n_frames;
    logic                n_vsync;
    logic                n_changed;
    logic [LIM_W-1:0]    scaled_sum;
    logic                on_ok;

    // ---------------- sample cell chain ----------------
    t_cell_ctrl        cell_ctrl;
    logic [RATE_W-1:0] cell_value [SAMPLE_COUNT];
    logic [RATE_W-1:0] clamped;
    logic              is_frame;
    logic              do_sample;

    assign is_frame  = s_accept && (i_s_tuser == KIND_FRAME) && r_adaptive;
    assign clamped   = (i_s_tdata < r_target) ? i_s_tdata : r_target;
    assign do_sample = is_frame && r_sampling && (r_frames == FRAMES_MAX);

    assign cell_ctrl.shift = do_sample;
    assign cell_ctrl.load  = s_accept && (i_s_tuser == KIND_REFILL);

    for (genvar k = 0; k < SAMPLE_COUNT; k++) begin : g_cell
        logic [RATE_W-1:0] prev;
        if (k == 0) begin : g_head
            assign prev = clamped;
        end else begin : g_link
            assign prev = cell_value[k-1];
        end
        avgov_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_prev  (prev),
            .i_fill  (r_target),
            .o_value (cell_value[k])
        );
    end

    // ---------------- sum, warm-up and hysteresis ----------------
    always_comb begin
        n_sum     = r_sum;
        n_frames  = r_frames;
        n_vsync   = r_vsync;
        n_changed = 1'b0;
        if (cell_ctrl.load) begin
            n_sum = SUM_W'(SUM_W'(r_target) * SUM_W'(SAMPLE_COUNT));
        end else if (do_sample) begin
            // oldest sample drops off the far end of the chain
            n_sum = r_sum - SUM_W'(cell_value[SAMPLE_COUNT-1]) + SUM_W'(clamped);
        end
        if (is_frame && (r_frames != FRAMES_MAX)) begin
            n_frames = r_frames + FRAMES_W'(1);
        end
        scaled_sum = {n_sum, {FRAC_W{1'b0}}};
        on_ok      = r_on_always || (n_sum >= r_on_limit);
        if (is_frame) begin
            priority if (r_vsync && (scaled_sum <= r_off_limit)) begin
                n_vsync   = 1'b0;
                n_changed = 1'b1;
            end else if (!r_vsync && on_ok) begin
                n_vsync   = 1'b1;
                n_changed = 1'b1;
            end else begin
                n_vsync = r_vsync;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= RESET_SUM;
            r_frames <= '0;
            r_vsync  <= 1'b1;
        end else if (s_accept) begin
            r_sum    <= n_sum;
            r_frames <= n_frames;
            r_vsync  <= n_vsync;
        end
    end

    // ---------------- stage 1: hold the result snapshot ----------------
    logic [SUM_W-1:0] r_s1_sum;
    logic             r_s1_vsync;
    logic             r_s1_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s_accept) begin
            r_v1 <= 1'b1;
        end else if (s1_move) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_sum     <= n_sum;
            r_s1_vsync   <= n_vsync;
            r_s1_changed <= n_changed;
        end
    end

    // ---------------- stage 2: average and output register ----------------
    logic [RATE_W-1:0] s1_mean;
    logic [23:0]       r_out;

    avgov_mean #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_mean (
        .i_sum  (r_s1_sum),
        .o_mean (s1_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s1_move) begin
            r_v2 <= 1'b1;
        end else if (i_m_tready) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= {6'd0, s1_mean, r_s1_changed, r_s1_vsync};
        end
    end

    assign o_m_tdata = r_out;

    // ---------------- assertions ----------------
    // refill leaves exactly N times the target in the running sum
    a_refill_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_s_tuser == KIND_REFILL)) |=>
            (r_sum == SUM_W'(SUM_W'($past(r_target)) * SUM_W'(SAMPLE_COUNT))))
        else $error("running sum does not match refill value");

    // the vsync decision moves only on an accepted frame request
    a_vsync_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vsync != $past(r_vsync)) |->
            ($past(s_accept) && ($past(i_s_tuser) == KIND_FRAME) && $past(r_adaptive)))
        else $error("vsync decision changed without a frame request");

    // the chain shifts only once warm-up is over
    a_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctrl.shift |-> ((r_frames == FRAMES_MAX) && !cell_ctrl.load))
        else $error("sample shifted in before warm-up ended");

    // a toggle pulse always goes with a flipped decision
    a_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && n_changed) |=> (r_vsync != $past(r_vsync)))
        else $error("toggle pulse without a decision change");

endmodule
